@@ rtl/core/stbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// shared constants, codes and controller/datapath interface types for the
// sorted table binary search core
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  typedef struct packed {
    logic load_wr;     // write one table word
    logic init;        // open the search range
    logic probe_first; // read at the midpoint of the open range
    logic probe_next;  // narrow the range and read at its new midpoint
    logic emit;        // register a result
    logic emit_hit;    // result is a match
  } cmd_t;

  typedef struct packed {
    logic first_empty; // open range holds no entry
    logic hit;         // probed word equals the key
    logic next_empty;  // narrowed range holds no entry
  } status_t;

  function automatic logic [IDX_W-1:0] midpoint(input logic [CNT_W-1:0] lo,
                                                input logic [CNT_W-1:0] hi);
    logic [CNT_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} - {{CNT_W{1'b0}}, 1'b1};
    return sum[IDX_W:1];
  endfunction

endpackage

@@ rtl/core/sorted_table_binary_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// binary search over a loaded table of signed words, one probe per cycle
// ----------------------------------------------------------------------------
// load: written in the cycle it is accepted, busy stays low, no result
// search: the range opens, then each probe reads the midpoint word and narrows
//   the range until a hit or an empty range; out_valid is registered at the end
// next request is taken in the cycle the result strobe is shown
// rst_n clears the state machine and entries_r; table contents stay
//   undefined until loaded
module sorted_table_binary_search_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_op,
  input  logic [stbs_pkg::IDX_W-1:0]         in_write_index,
  input  logic signed [stbs_pkg::DATA_W-1:0] in_write_value,
  input  logic signed [stbs_pkg::DATA_W-1:0] in_search_key,
  input  logic                               cfg_wr_en,
  input  logic [stbs_pkg::CNT_W-1:0]         cfg_wr_data,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [stbs_pkg::IDX_W-1:0]         out_found_index
);
  import stbs_pkg::*;

  cmd_t    cmd;
  status_t status;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_op),
    .busy      (busy),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid)
  );

  stbs_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_write_index  (in_write_index),
    .in_write_value  (in_write_value),
    .in_search_key   (in_search_key),
    .out_found       (out_found),
    .out_found_index (out_found_index)
  );

endmodule

@@ rtl/core/stbs_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_dpath
// table memory, search bounds, key compare and result registers
// ----------------------------------------------------------------------------
module stbs_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stbs_pkg::cmd_t               cmd,
  output stbs_pkg::status_t            status,
  input  logic                         cfg_wr_en,
  input  logic [stbs_pkg::CNT_W-1:0]   cfg_wr_data,
  input  logic [stbs_pkg::IDX_W-1:0]   in_write_index,
  input  logic signed [stbs_pkg::DATA_W-1:0] in_write_value,
  input  logic signed [stbs_pkg::DATA_W-1:0] in_search_key,
  output logic                         out_found,
  output logic [stbs_pkg::IDX_W-1:0]   out_found_index
);
  import stbs_pkg::*;

  logic signed [DATA_W-1:0] table_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  logic [CNT_W-1:0]         entries_r;
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hi_r, hi_nxt;
  logic [IDX_W-1:0]         mid_r;
  logic signed [DATA_W-1:0] key_r;
  logic [CNT_W-1:0]         lo_step, hi_step;
  logic [IDX_W-1:0]         mid_cur, mid_step, rd_addr;
  logic                     rd_en;
  logic                     found_r;
  logic [IDX_W-1:0]         found_index_r;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      table_mem[in_write_index] <= in_write_value;
    end
    if (rd_en) begin
      rdata_r <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else if (cfg_wr_en) begin
      entries_r <= (cfg_wr_data > DEPTH_CNT) ? DEPTH_CNT : cfg_wr_data;
    end
  end

  // narrowed bounds from the word just read
  always_comb begin
    if (key_r > rdata_r) begin
      lo_step = {1'b0, mid_r} + {{IDX_W{1'b0}}, 1'b1};
      hi_step = hi_r;
    end else begin
      lo_step = lo_r;
      hi_step = {1'b0, mid_r};
    end
  end

  assign mid_cur  = midpoint(lo_r, hi_r);
  assign mid_step = midpoint(lo_step, hi_step);
  assign rd_en    = cmd.probe_first | cmd.probe_next;
  assign rd_addr  = cmd.probe_next ? mid_step : mid_cur;

  assign status.first_empty = (lo_r >= hi_r);
  assign status.hit         = (key_r == rdata_r);
  assign status.next_empty  = (lo_step >= hi_step);

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.init) begin
      lo_nxt = '0;
      hi_nxt = entries_r;
    end else if (cmd.probe_next) begin
      lo_nxt = lo_step;
      hi_nxt = hi_step;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.init) begin
      key_r <= in_search_key;
    end
    if (rd_en) begin
      mid_r <= rd_addr;
    end
    if (cmd.emit) begin
      found_r       <= cmd.emit_hit;
      found_index_r <= cmd.emit_hit ? mid_r : '0;
    end
  end

  assign out_found       = found_r;
  assign out_found_index = found_index_r;

endmodule

@@ rtl/core/stbs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ctrl
// request sequencing: table loads, probe loop and result strobe
// ----------------------------------------------------------------------------
module stbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_op,
  output logic                busy,
  output stbs_pkg::cmd_t      cmd,
  input  stbs_pkg::status_t   status,
  output logic                out_valid
);
  import stbs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FIRST = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       valid_r, valid_nxt;
  logic       accept;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.init  = 1'b1;
            state_nxt = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (status.first_empty) begin
          cmd.emit  = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.probe_first = 1'b1;
          state_nxt       = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (status.hit) begin
          cmd.emit     = 1'b1;
          cmd.emit_hit = 1'b1;
          valid_nxt    = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (status.next_empty) begin
          cmd.emit  = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;

  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> state_r == ST_IDLE)
    else $error("result strobe while search still running");

  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == OP_LOAD |=> !busy && !valid_r)
    else $error("load request left the core busy or gave a result");

  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == OP_SEARCH |=> state_r == ST_FIRST)
    else $error("search request did not open a range");

  a_probe_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PROBE |-> $past(state_r) == ST_FIRST || $past(state_r) == ST_PROBE)
    else $error("probe state entered without a first probe");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for sorted_table_binary_search_core: fills the table
// with non-decreasing words, then sends bursts of loads and searches under
// several table sizes, predicting every search outcome and comparing it
// against each result strobe
// ----------------------------------------------------------------------------
module tb;
  import stbs_pkg::*;

  localparam int     SETTLE     = 16;
  localparam int     LIMIT      = 600000;
  localparam int     RAND_ITEMS = 760;
  localparam longint MIN_WORD   = -(longint'(1) <<< 31);
  localparam longint MAX_WORD   = (longint'(1) <<< 31) - 1;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } answer_t;

  class search_tracker;
    logic signed [DATA_W-1:0] words [TABLE_DEPTH];
    logic [CNT_W-1:0]         entries;
    answer_t                  due_answers [$];
    int                       mismatches;
    int                       searches;
    int                       hits;

    function new();
      entries    = '0;
      mismatches = 0;
      searches   = 0;
      hits       = 0;
    endfunction

    function void set_entries(logic [CNT_W-1:0] value);
      entries = value;
    endfunction

    function int pending();
      return due_answers.size();
    endfunction

    function answer_t lookup(logic signed [DATA_W-1:0] key);
      int      lo;
      int      hi;
      int      mid;
      answer_t ans;
      ans = '0;
      lo  = 0;
      hi  = ((entries > DEPTH_CNT) ? TABLE_DEPTH : int'(entries)) - 1;
      while (lo <= hi && !ans.found) begin
        mid = (lo + hi) / 2;
        if (key > words[mid]) begin
          lo = mid + 1;
        end else if (key < words[mid]) begin
          hi = mid - 1;
        end else begin
          ans.found = 1'b1;
          ans.index = mid[IDX_W-1:0];
        end
      end
      return ans;
    endfunction

    function void note_request(logic op, logic [IDX_W-1:0] widx,
                               logic signed [DATA_W-1:0] wval,
                               logic signed [DATA_W-1:0] key);
      answer_t ans;
      if (op == OP_LOAD) begin
        words[widx] = wval;
      end else begin
        ans = lookup(key);
        due_answers.push_back(ans);
        searches++;
        if (ans.found) hits++;
      end
    endfunction

    function void check_result(logic found, logic [IDX_W-1:0] index);
      answer_t want;
      if (due_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0b index=%0d", found, index);
      end else begin
        want = due_answers.pop_front();
        if (found !== want.found || index !== want.index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("search mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                     want.found, want.index, found, index);
        end
      end
    endfunction
  endclass

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     start           = 1'b0;
  logic                     in_op           = OP_LOAD;
  logic [IDX_W-1:0]         in_write_index  = '0;
  logic signed [DATA_W-1:0] in_write_value  = '0;
  logic signed [DATA_W-1:0] in_search_key   = '0;
  logic                     cfg_wr_en       = 1'b0;
  logic [CNT_W-1:0]         cfg_wr_data     = '0;
  logic                     busy;
  logic                     out_valid;
  logic                     out_found;
  logic [IDX_W-1:0]         out_found_index;

  search_tracker sb = new();
  int            cycles     = 0;
  int            sent       = 0;
  int            settings   = 0;
  int            burst_left = 1;
  bit            steady     = 1'b0;

  sorted_table_binary_search_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_write_index  (in_write_index),
    .in_write_value  (in_write_value),
    .in_search_key   (in_search_key),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_found_index (out_found_index)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid) sb.check_result(out_found, out_found_index);
      if (start && !busy)
        sb.note_request(in_op, in_write_index, in_write_value, in_search_key);
      if (cfg_wr_en) begin
        sb.set_entries(cfg_wr_data);
        settings++;
      end
    end
  end

  initial begin
    while (cycles < LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic pace();
    int gap;
    if (!steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
        start <= 1'b0;
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic issue(logic op, logic [IDX_W-1:0] widx,
                       logic signed [DATA_W-1:0] wval,
                       logic signed [DATA_W-1:0] key);
    start          <= 1'b1;
    in_op          <= op;
    in_write_index <= widx;
    in_write_value <= wval;
    in_search_key  <= key;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
    pace();
  endtask

  task automatic load_word(int idx, longint value);
    issue(OP_LOAD, idx[IDX_W-1:0], value[DATA_W-1:0], $urandom);
  endtask

  task automatic search_for(longint key);
    issue(OP_SEARCH, IDX_W'($urandom), $urandom, key[DATA_W-1:0]);
  endtask

  // rewrite entries a..b-1 with non-decreasing values that fit between their neighbors
  task automatic refill(int a, int b);
    longint lo_b;
    longint hi_b;
    longint cur;
    longint room;
    longint step;
    int     i;
    lo_b = (a > 0) ? longint'(sb.words[a-1]) : MIN_WORD;
    hi_b = (b < TABLE_DEPTH) ? longint'(sb.words[b]) : MAX_WORD;
    if (hi_b < lo_b) hi_b = lo_b;
    cur = lo_b;
    for (i = a; i < b; i++) begin
      room = hi_b - cur;
      step = 0;
      if (room > 0 && $urandom_range(0, 7) != 0)
        step = longint'($urandom) % (room / (b - i) * 2 + 1);
      if (step > room) step = room;
      cur += step;
      load_word(i, cur);
    end
  endtask

  task automatic set_entries(int value);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[CNT_W-1:0];
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
    burst_left = $urandom_range(1, 12);
  endtask

  function automatic longint pick_key(int span);
    int     sel;
    longint w;
    longint k;
    sel = $urandom_range(0, 19);
    w   = (span > 0) ? longint'(sb.words[$urandom_range(0, span - 1)]) : 0;
    if (span == 0 || sel >= 15) k = longint'($urandom);
    else if (sel == 14)         k = MIN_WORD;
    else if (sel == 13)         k = MAX_WORD;
    else if (sel == 12)         k = w - 1;
    else if (sel == 11)         k = w + 1;
    else                        k = w;
    return k;
  endfunction

  task automatic run_phase();
    int n;
    int span;
    int count;
    int base;
    int r;
    int a;
    int b;
    r = $urandom_range(0, 15);
    case (r)
      0:       n = 0;
      1:       n = $urandom_range(TABLE_DEPTH + 1, (1 << CNT_W) - 1);
      2, 3:    n = TABLE_DEPTH;
      4:       n = $urandom_range(65, TABLE_DEPTH - 1);
      default: n = $urandom_range(1, 64);
    endcase
    set_entries(n);
    span   = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    steady = ($urandom_range(0, 3) == 0);
    count  = $urandom_range(40, 120);
    base   = sent;
    while (sent - base < count) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        search_for(pick_key(span));
      end else if (r == 14) begin
        // stray write, may leave the table out of order
        load_word($urandom_range(0, TABLE_DEPTH - 1), longint'($urandom));
      end else begin
        a = (span > 0 && $urandom_range(0, 1) == 1) ? $urandom_range(0, span - 1)
                                                    : $urandom_range(0, TABLE_DEPTH - 1);
        b = a + $urandom_range(1, 8);
        if (b > TABLE_DEPTH) b = TABLE_DEPTH;
        refill(a, b);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    int base;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full sorted table with both word extremes at the ends
    set_entries(TABLE_DEPTH);
    refill(0, TABLE_DEPTH);
    load_word(0, MIN_WORD);
    load_word(TABLE_DEPTH - 1, MAX_WORD);
    search_for(MIN_WORD);
    search_for(MAX_WORD);
    search_for(sb.words[511]);
    search_for(longint'(sb.words[300]) + 1);
    search_for(longint'(sb.words[1000]) - 1);
    search_for(longint'($urandom));

    // empty range
    set_entries(0);
    search_for(sb.words[0]);

    // oversized setting saturates to the table depth
    set_entries((1 << CNT_W) - 1);
    search_for(sb.words[TABLE_DEPTH - 1]);
    search_for(sb.words[700]);

    set_entries(1);
    search_for(sb.words[0]);
    search_for(longint'(sb.words[0]) - 1);
    search_for(longint'(sb.words[0]) + 1);

    set_entries(3);
    search_for(sb.words[0]);
    search_for(sb.words[1]);
    search_for(sb.words[2]);
    search_for(MAX_WORD);

    base = sent;
    while (sent - base < RAND_ITEMS) run_phase();

    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("sent %0d requests: %0d searches checked, %0d expected to hit",
             sent, sb.searches, sb.hits);
    $display("table size changed %0d times, %0d result mismatches", settings, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
